@@ src/servo_joint_ramp_generator_defines.svh @@
// ============================================================================
// Servo joint ramp generator assertion macros
// Shared concurrent assertion macros; they expand to nothing in synthesis.
// ============================================================================
`ifndef SERVO_JOINT_RAMP_GENERATOR_DEFINES_SVH
`define SERVO_JOINT_RAMP_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SJRG_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sjrg: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define SJRG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sjrg: next-cycle check failed");
`else
`define SJRG_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define SJRG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ src/sjrg_pkg.sv @@
// ============================================================================
// Servo joint ramp generator package
// Widths, codes, reset values and the controller/datapath interface types.
// ============================================================================
package sjrg_pkg;

    localparam int FRAC_BITS_DEF = 20;
    localparam int POS_WIDTH_DEF = 24;

    localparam int REQ_W      = 3;
    localparam int PW_W       = 12;
    localparam int ANGLE_W    = 24;
    localparam int SPEED_W    = 16;
    localparam int TMS_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int VEL_W      = 26;
    localparam int TPS_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    // pi/2 scaled by 2^32 and rounded is 6746518852. The speed term divides it
    // by 1000, so it is kept split into quotient and remainder by 1000.
    localparam int HALF_PI_W = 33;
    localparam int Q32_FRAC  = 32;
    localparam logic [22:0] HALF_PI_DIV_MS = 23'd6746518;
    localparam logic [9:0]  HALF_PI_MOD_MS = 10'd852;

    // floor(x / 1000) equals (x * RECIP_MS) >> RECIP_SHIFT for x below 2^26.
    localparam int SPD_LO_W    = 26;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_MS = 27'd68719477;

    localparam logic [SPEED_W-1:0] SPEED_DEFAULT = 16'd1000;
    localparam logic [TMS_W-1:0]   MS_PER_S      = 16'd1000;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_MOVE_PULSE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MOVE_ANGLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_POS    = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STARTED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_AT_TARGET   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PULSE_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE        = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PW_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PW_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VLIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 3'd5;

    // Configuration reset values.
    localparam logic [PW_W-1:0]           PW_MIN_RST = 12'd500;
    localparam logic [PW_W-1:0]           PW_MAX_RST = 12'd2500;
    localparam logic signed [ANGLE_W-1:0] A_MIN_RST  = -24'sd1647099;
    localparam logic signed [ANGLE_W-1:0] A_MAX_RST  = 24'sd1647099;
    localparam logic [VEL_W-1:0]          VLIM_RST   = 26'd3294199;
    localparam logic [TPS_W-1:0]          TPS_RST    = 14'd1000;

    typedef enum logic [1:0] {MUL_MAP, MUL_SPEED, MUL_DIST} mul_sel_t;
    typedef enum logic [1:0] {DIV_MAP, DIV_TIME, DIV_STEP} div_sel_t;
    typedef enum logic [1:0] {TGT_ANGLE, TGT_AMIN, TGT_MAP} tgt_src_t;

    typedef struct packed {
        logic                load_in;
        logic                mul_go;
        mul_sel_t            mul_sel;
        logic                spd_frac;
        logic                div_go;
        div_sel_t            div_sel;
        logic                set_target;
        tgt_src_t            tgt_src;
        logic                set_vs;
        logic                set_vt;
        logic                set_vel;
        logic                set_step;
        logic                do_stop;
        logic                do_tick;
        logic                do_setpos;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } sjrg_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             pw_bad;
        logic             span_zero;
        logic             at_target;
        logic             tms_zero;
        logic             div_done;
    } sjrg_stat_t;

endpackage

@@ src/sjrg_div.sv @@
// ============================================================================
// Servo joint ramp generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module sjrg_div #(
    parameter int DW = 49,
    parameter int VW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [VW:0]    rem_reg, rem_next, shifted;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [VW-1:0]  dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg, done_reg, fits;

    always_comb begin
        shifted  = {rem_reg[VW-1:0], quo_reg[DW-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? shifted - {1'b0, dvs_reg} : shifted;
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/sjrg_datapath.sv @@
// ============================================================================
// Servo joint ramp generator datapath
// Configuration, joint state, shared multiplier and divider, result register.
// ============================================================================
module sjrg_datapath #(
    parameter int FRAC_BITS = 20,
    parameter int POS_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [sjrg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sjrg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [sjrg_pkg::REQ_W-1:0]            req_type,
    input  logic [sjrg_pkg::PW_W-1:0]             pulse_width,
    input  logic signed [sjrg_pkg::ANGLE_W-1:0]   angle,
    input  logic [sjrg_pkg::SPEED_W-1:0]          speed,
    input  logic [sjrg_pkg::TMS_W-1:0]            move_time_ms,
    input  sjrg_pkg::sjrg_cmd_t                   cmd,
    output sjrg_pkg::sjrg_stat_t                  stat,
    output logic [sjrg_pkg::STATUS_W-1:0]         out_status,
    output logic signed [sjrg_pkg::ANGLE_W-1:0]   out_position,
    output logic signed [sjrg_pkg::ANGLE_W-1:0]   out_target,
    output logic [sjrg_pkg::VEL_W-1:0]            out_velocity,
    output logic                                  out_clamped
);
    import sjrg_pkg::*;

    localparam int EW  = (POS_WIDTH > ANGLE_W) ? POS_WIDTH : ANGLE_W;
    localparam int CW  = ((POS_WIDTH > VEL_W) ? POS_WIDTH : VEL_W) + 1;
    localparam int AW  = (POS_WIDTH > HALF_PI_W) ? POS_WIDTH : HALF_PI_W;
    localparam int DW  = AW + SPEED_W;
    localparam int AXW = ANGLE_W + 1;
    localparam int SPD_SHIFT = Q32_FRAC - FRAC_BITS;
    localparam int FP_W = SPD_LO_W + RECIP_W;
    localparam int FQ_W = FP_W - RECIP_SHIFT;
    localparam logic signed [EW-1:0] POS_HI =
        {{(EW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [EW-1:0] POS_LO = ~POS_HI;

    // Configuration registers.
    logic [PW_W-1:0]           pw_min_reg, pw_max_reg;
    logic signed [ANGLE_W-1:0] a_min_reg, a_max_reg;
    logic [VEL_W-1:0]          vlim_reg;
    logic [TPS_W-1:0]          tps_reg;

    // Latched request.
    logic [REQ_W-1:0]          req_reg;
    logic [PW_W-1:0]           pw_reg;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [TMS_W-1:0]          tms_reg;

    // Joint state and move scratch.
    logic signed [POS_WIDTH-1:0] cur_reg, tgt_reg;
    logic [VEL_W-1:0]            vel_reg, step_reg, vs_reg, vt_reg;
    logic                        clamp_reg;
    logic [DW-1:0]               prod_reg;
    logic [SPD_LO_W-1:0]         spd_lo_reg;
    logic [FQ_W-1:0]             spd_frac_reg;

    // Result register.
    logic [STATUS_W-1:0]       ost_reg;
    logic signed [ANGLE_W-1:0] opos_reg, otgt_reg;
    logic [VEL_W-1:0]          ovel_reg;
    logic                      oclamp_reg;

    logic [PW_W-1:0]           pw_off, span;
    logic signed [AXW-1:0]     adiff;
    logic [AXW-1:0]            adiff_mag, map_q;
    logic signed [AXW:0]       map_sum, map_off;
    logic signed [ANGLE_W-1:0] tgt_in;
    logic signed [POS_WIDTH:0] diff;
    logic [POS_WIDTH-1:0]      dist_mag;
    logic signed [CW-1:0]      cur_ext, stepped;
    logic [CW-1:0]             step_ext, dist_ext;
    logic signed [POS_WIDTH-1:0] tick_pos;
    logic [SPEED_W-1:0]        speed_eff;
    logic [TPS_W-1:0]          tps_eff;
    logic [AW-1:0]             mul_a;
    logic [SPEED_W-1:0]        mul_b;
    logic [DW-1:0]             div_a, quo, spd_sum, spd_shifted;
    logic [FP_W-1:0]           frac_prod;
    logic [TMS_W-1:0]          div_b;
    logic                      div_done;
    logic [VEL_W-1:0]          vs_sat, vt_sat, vmax, vel_new;
    logic                      clamp_new;
    logic signed [EW-1:0]      pos_w, tgt_w;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [ANGLE_W-1:0] v
    );
        logic signed [EW-1:0] x;
        x = EW'(v);
        if (x > POS_HI) begin
            x = POS_HI;
        end else if (x < POS_LO) begin
            x = POS_LO;
        end
        return x[POS_WIDTH-1:0];
    endfunction

    always_comb begin
        // Linear pulse-to-angle map; magnitude divide keeps truncation toward zero.
        pw_off    = pw_reg - pw_min_reg;
        span      = pw_max_reg - pw_min_reg;
        adiff     = AXW'(a_max_reg) - AXW'(a_min_reg);
        adiff_mag = adiff[AXW-1] ? AXW'(-adiff) : AXW'(adiff);
        map_q     = quo[AXW-1:0];
        map_off   = signed'({1'b0, map_q});
        map_sum   = (AXW + 1)'(a_min_reg) + (adiff[AXW-1] ? -map_off : map_off);

        case (cmd.tgt_src)
            TGT_ANGLE: tgt_in = ang_reg;
            TGT_AMIN:  tgt_in = a_min_reg;
            TGT_MAP:   tgt_in = map_sum[ANGLE_W-1:0];
            default:   tgt_in = ang_reg;
        endcase

        diff     = (POS_WIDTH + 1)'(tgt_reg) - (POS_WIDTH + 1)'(cur_reg);
        dist_mag = diff[POS_WIDTH] ? POS_WIDTH'(-diff) : POS_WIDTH'(diff);

        // One tick toward the target, landing on it when within one step.
        cur_ext  = CW'(cur_reg);
        step_ext = CW'(step_reg);
        dist_ext = CW'(dist_mag);
        stepped  = diff[POS_WIDTH] ? cur_ext - signed'(step_ext)
                                   : cur_ext + signed'(step_ext);
        tick_pos = (dist_ext < step_ext) ? tgt_reg : stepped[POS_WIDTH-1:0];

        speed_eff = (speed_reg == '0 && tms_reg == '0) ? SPEED_DEFAULT : speed_reg;
        tps_eff   = (tps_reg == '0) ? TPS_W'(1) : tps_reg;

        case (cmd.mul_sel)
            MUL_MAP: begin
                mul_a = AW'(adiff_mag);
                mul_b = SPEED_W'(pw_off);
            end
            MUL_SPEED: begin
                mul_a = AW'(HALF_PI_DIV_MS);
                mul_b = speed_eff;
            end
            MUL_DIST: begin
                mul_a = AW'(dist_mag);
                mul_b = MS_PER_S;
            end
            default: begin
                mul_a = AW'(dist_mag);
                mul_b = MS_PER_S;
            end
        endcase

        case (cmd.div_sel)
            DIV_MAP: begin
                div_a = prod_reg;
                div_b = TMS_W'(span);
            end
            DIV_TIME: begin
                div_a = prod_reg;
                div_b = tms_reg;
            end
            DIV_STEP: begin
                div_a = DW'(vel_reg);
                div_b = TMS_W'(tps_eff);
            end
            default: begin
                div_a = prod_reg;
                div_b = tms_reg;
            end
        endcase

        // Speed term: speed * (pi/2 * 2^32) / 1000 is speed times the quotient
        // part plus the remainder part divided by 1000 through a reciprocal.
        frac_prod   = FP_W'(spd_lo_reg) * FP_W'(RECIP_MS);
        spd_sum     = prod_reg + DW'(spd_frac_reg);
        spd_shifted = spd_sum >> SPD_SHIFT;
        vs_sat = (|spd_shifted[DW-1:VEL_W]) ? '1 : spd_shifted[VEL_W-1:0];
        vt_sat = (|quo[DW-1:VEL_W]) ? '1 : quo[VEL_W-1:0];
        vmax      = (vt_reg > vs_reg) ? vt_reg : vs_reg;
        clamp_new = vmax > vlim_reg;
        vel_new   = clamp_new ? vlim_reg : vmax;

        pos_w = EW'(cur_reg);
        tgt_w = EW'(tgt_reg);
    end

    sjrg_div #(
        .DW(DW),
        .VW(TMS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .dividend(div_a),
        .divisor (div_b),
        .done    (div_done),
        .quotient(quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_min_reg <= PW_MIN_RST;
            pw_max_reg <= PW_MAX_RST;
            a_min_reg  <= A_MIN_RST;
            a_max_reg  <= A_MAX_RST;
            vlim_reg   <= VLIM_RST;
            tps_reg    <= TPS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PW_MIN: pw_min_reg <= cfg_wdata[PW_W-1:0];
                CFG_PW_MAX: pw_max_reg <= cfg_wdata[PW_W-1:0];
                CFG_A_MIN:  a_min_reg  <= cfg_wdata[ANGLE_W-1:0];
                CFG_A_MAX:  a_max_reg  <= cfg_wdata[ANGLE_W-1:0];
                CFG_VLIM:   vlim_reg   <= cfg_wdata[VEL_W-1:0];
                CFG_TPS:    tps_reg    <= cfg_wdata[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            tgt_reg  <= '0;
            vel_reg  <= '0;
            step_reg <= '0;
        end else begin
            if (cmd.set_target) begin
                tgt_reg <= sat_pos(tgt_in);
            end
            if (cmd.do_stop) begin
                vel_reg <= '0;
                tgt_reg <= cur_reg;
            end
            if (cmd.do_tick && (tgt_reg != cur_reg)) begin
                cur_reg <= tick_pos;
            end
            if (cmd.do_setpos) begin
                cur_reg <= sat_pos(ang_reg);
            end
            if (cmd.set_vel) begin
                vel_reg <= vel_new;
            end
            if (cmd.set_step) begin
                step_reg <= quo[VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg   <= req_type;
            pw_reg    <= pulse_width;
            ang_reg   <= angle;
            speed_reg <= speed;
            tms_reg   <= move_time_ms;
            clamp_reg <= 1'b0;
        end else if (cmd.set_vel) begin
            clamp_reg <= clamp_new;
        end
        if (cmd.mul_go) begin
            prod_reg <= DW'(mul_a * mul_b);
        end
        if (cmd.mul_go && (cmd.mul_sel == MUL_SPEED)) begin
            spd_lo_reg <= SPD_LO_W'(speed_eff) * SPD_LO_W'(HALF_PI_MOD_MS);
        end
        if (cmd.spd_frac) begin
            spd_frac_reg <= frac_prod[FP_W-1:RECIP_SHIFT];
        end
        if (cmd.set_vs) begin
            vs_reg <= vs_sat;
            vt_reg <= '0;
        end else if (cmd.set_vt) begin
            vt_reg <= vt_sat;
        end
        if (cmd.out_load) begin
            ost_reg    <= cmd.status;
            opos_reg   <= pos_w[ANGLE_W-1:0];
            otgt_reg   <= tgt_w[ANGLE_W-1:0];
            ovel_reg   <= vel_reg;
            oclamp_reg <= clamp_reg;
        end
    end

    always_comb begin
        stat.req_type  = req_reg;
        stat.pw_bad    = (pw_reg < pw_min_reg) || (pw_reg > pw_max_reg);
        stat.span_zero = pw_max_reg == pw_min_reg;
        stat.at_target = tgt_reg == cur_reg;
        stat.tms_zero  = tms_reg == '0;
        stat.div_done  = div_done;
    end

    assign out_status   = ost_reg;
    assign out_position = opos_reg;
    assign out_target   = otgt_reg;
    assign out_velocity = ovel_reg;
    assign out_clamped  = oclamp_reg;

endmodule

@@ src/sjrg_ctrl.sv @@
// ============================================================================
// Servo joint ramp generator controller
// Sequences each request through the shared multiplier and divider.
// ============================================================================
module sjrg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    input  sjrg_pkg::sjrg_stat_t stat,
    output sjrg_pkg::sjrg_cmd_t  cmd
);
    import sjrg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MAP_MUL, S_MAP_DIV, S_MAP_WAIT, S_CHECK,
        S_SPD_FRAC, S_SPD_SUM, S_TIME_MUL, S_TIME_DIV, S_TIME_WAIT,
        S_VEL, S_STEP_DIV, S_STEP_WAIT, S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                valid_reg, valid_next;

    always_comb begin
        cmd         = '0;
        cmd.status  = status_reg;
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = ST_DONE;
                state_next  = S_FINISH;
                case (stat.req_type)
                    REQ_MOVE_PULSE: begin
                        if (stat.pw_bad) begin
                            status_next = ST_PULSE_RANGE;
                        end else if (stat.span_zero) begin
                            cmd.set_target = 1'b1;
                            cmd.tgt_src    = TGT_AMIN;
                            state_next     = S_CHECK;
                        end else begin
                            state_next = S_MAP_MUL;
                        end
                    end
                    REQ_MOVE_ANGLE: begin
                        cmd.set_target = 1'b1;
                        cmd.tgt_src    = TGT_ANGLE;
                        state_next     = S_CHECK;
                    end
                    REQ_STOP:    cmd.do_stop   = 1'b1;
                    REQ_TICK:    cmd.do_tick   = 1'b1;
                    REQ_SET_POS: cmd.do_setpos = 1'b1;
                    default: ;
                endcase
            end
            S_MAP_MUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_MAP;
                state_next  = S_MAP_DIV;
            end
            S_MAP_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_MAP;
                state_next  = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                if (stat.div_done) begin
                    cmd.set_target = 1'b1;
                    cmd.tgt_src    = TGT_MAP;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.at_target) begin
                    status_next = ST_AT_TARGET;
                    state_next  = S_FINISH;
                end else begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = MUL_SPEED;
                    state_next  = S_SPD_FRAC;
                end
            end
            S_SPD_FRAC: begin
                cmd.spd_frac = 1'b1;
                state_next   = S_SPD_SUM;
            end
            S_SPD_SUM: begin
                cmd.set_vs = 1'b1;
                state_next = stat.tms_zero ? S_VEL : S_TIME_MUL;
            end
            S_TIME_MUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_DIST;
                state_next  = S_TIME_DIV;
            end
            S_TIME_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_TIME;
                state_next  = S_TIME_WAIT;
            end
            S_TIME_WAIT: begin
                if (stat.div_done) begin
                    cmd.set_vt = 1'b1;
                    state_next = S_VEL;
                end
            end
            S_VEL: begin
                cmd.set_vel = 1'b1;
                state_next  = S_STEP_DIV;
            end
            S_STEP_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_STEP;
                state_next  = S_STEP_WAIT;
            end
            S_STEP_WAIT: begin
                if (stat.div_done) begin
                    cmd.set_step = 1'b1;
                    status_next  = ST_STARTED;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_DONE;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = valid_reg;

endmodule

@@ src/servo_joint_ramp_generator.sv @@
// ============================================================================
// Servo joint ramp generator
// Move, stop, tick and set-position requests for one servo joint.
// ============================================================================
// Each request gives exactly one result transaction. Stop, tick, set-position
// and rejected pulse moves go from decode straight to the finish state. A
// move runs the shared multiplier and the shared bit-serial divider in turn:
// one divide for the pulse-to-angle map (pulse moves only), one for the time
// term (only with a nonzero move time) and one for the per-tick step. The
// speed term is a divide by a constant, done with a reciprocal multiply.
// The divider takes DW-bit dividends, DW being 16 + max(33, POS_WIDTH),
// 49 at the default widths, and the divides take most of a move's time. One
// request is worked on at a time; the next is accepted while the previous
// result still waits in the output register.
// ============================================================================
`include "servo_joint_ramp_generator_defines.svh"

module servo_joint_ramp_generator #(
    parameter int FRAC_BITS = sjrg_pkg::FRAC_BITS_DEF,
    parameter int POS_WIDTH = sjrg_pkg::POS_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Request channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pulse_width[11:0], angle[35:12], speed[51:36], move_time_ms[67:52], zero pad
    input  logic [sjrg_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type[2:0]
    input  logic [sjrg_pkg::IN_TUSER_W-1:0]      s_tuser,
    // Result channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // position[23:0], target[47:24], velocity[73:48], velocity_clamped[74], zero pad
    output logic [sjrg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [sjrg_pkg::OUT_TUSER_W-1:0]     m_tuser,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sjrg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sjrg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import sjrg_pkg::*;

    sjrg_cmd_t                 cmd;
    sjrg_stat_t                stat;
    logic [STATUS_W-1:0]       out_status;
    logic signed [ANGLE_W-1:0] out_position, out_target;
    logic [VEL_W-1:0]          out_velocity;
    logic                      out_clamped;

    // Registers can always be written; software keeps writes to idle periods.
    assign cfg_ready = 1'b1;

    // The controller owns the handshakes and sequencing.
    sjrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds configuration, joint state and the arithmetic.
    sjrg_datapath #(
        .FRAC_BITS(FRAC_BITS),
        .POS_WIDTH(POS_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req_type    (s_tuser[REQ_W-1:0]),
        .pulse_width (s_tdata[11:0]),
        .angle       (s_tdata[35:12]),
        .speed       (s_tdata[51:36]),
        .move_time_ms(s_tdata[67:52]),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (out_status),
        .out_position(out_position),
        .out_target  (out_target),
        .out_velocity(out_velocity),
        .out_clamped (out_clamped)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {5'b0, out_clamped, out_velocity, out_target, out_position};
    assign m_tuser = out_status;

    // Only one request is in flight, so acceptance always drops ready.
    `SJRG_ASSERT_NEXT(a_single_request, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // The clamp flag can only come from a move that was started.
    `SJRG_ASSERT_IMPLY(a_clamp_on_start, aclk, aresetn, m_tvalid && m_tdata[74], m_tuser == ST_STARTED)
    // An already-at-target result reports matching position and target.
    `SJRG_ASSERT_IMPLY(a_at_target_match, aclk, aresetn, m_tvalid && (m_tuser == ST_AT_TARGET), m_tdata[23:0] == m_tdata[47:24])

endmodule
